// ===== design/esc_pkg.sv =====
package esc_pkg;

   localparam logic [31:0] SecsPerDay  = 32'd86400;
   localparam logic [31:0] SecsPerHour = 32'd3600;
   localparam logic [31:0] SecsPerMin  = 32'd60;
   localparam logic [11:0] BaseYear    = 12'd1970;
   localparam logic [31:0] DaysLeapYr  = 32'd366;
   localparam logic [31:0] DaysPlainYr = 32'd365;
   localparam logic [3:0]  LastMonth   = 4'd11;

   // Fields of one converted time stamp.
   typedef struct packed {
      logic [5:0]  second_of_minute;
      logic [5:0]  minute_of_hour;
      logic [4:0]  hour_of_day;
      logic [11:0] year_number;
      logic [3:0]  month_number;
      logic [4:0]  day_of_month;
   } esc_result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } esc_status_type;

   // A 32-bit second count never reaches past 2106, so 2000 and 2100 are the only
   // century years that can show up, and only 2100 is not a leap year.
   function automatic logic is_leap(input logic [11:0] year);
      is_leap = (year[1:0] == 2'b00) && (year != 12'd2100);
   endfunction

   // Month index counts from 0 for January.
   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      unique case (mon)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      month_days = len;
   endfunction

endpackage

// ===== design/esc_subtract.sv =====
module esc_subtract import esc_pkg::*; (
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] diff,
   output logic        ge
);

   logic [32:0] wide_diff;

   assign wide_diff = {1'b0, a} - {1'b0, b};
   assign diff      = wide_diff[31:0];
   // No borrow out means a is at least b.
   assign ge        = ~wide_diff[32];

endmodule

// ===== design/esc_core.sv =====
module esc_core import esc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [31:0]    secs,
   input  logic           take,
   output esc_status_type status,
   output esc_result_type result
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DAYS   = 3'd1;
   localparam logic [2:0] ST_HOURS  = 3'd2;
   localparam logic [2:0] ST_MINS   = 3'd3;
   localparam logic [2:0] ST_YEARS  = 3'd4;
   localparam logic [2:0] ST_MONTHS = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [15:0] days_ff, days_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  mon_ff, mon_in;

   logic [31:0] sub_b, sub_diff;
   logic        sub_ge, leap;

   assign leap = is_leap(year_ff);

   // Operand for the shared subtractor: a shifted divisor during the
   // long divisions, then a year or month length during the walks.
   always_comb begin
      unique case (state_ff)
         ST_DAYS:   sub_b = SecsPerDay << step_ff;
         ST_HOURS:  sub_b = SecsPerHour << step_ff;
         ST_MINS:   sub_b = SecsPerMin << step_ff;
         ST_YEARS:  sub_b = leap ? DaysLeapYr : DaysPlainYr;
         ST_MONTHS: sub_b = {27'd0, month_days(mon_ff, leap)};
         default:   sub_b = 32'd0;
      endcase
   end

   esc_subtract u_subtract (
      .a    (rem_ff),
      .b    (sub_b),
      .diff (sub_diff),
      .ge   (sub_ge)
   );

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      days_in  = days_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      year_in  = year_ff;
      mon_in   = mon_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_in   = secs;
               step_in  = 4'd15;
               state_in = ST_DAYS;
            end
         end
         ST_DAYS: begin
            if (sub_ge) rem_in = sub_diff;
            days_in = {days_ff[14:0], sub_ge};
            if (step_ff == 4'd0) begin
               step_in  = 4'd4;
               state_in = ST_HOURS;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_HOURS: begin
            if (sub_ge) rem_in = sub_diff;
            hour_in = {hour_ff[3:0], sub_ge};
            if (step_ff == 4'd0) begin
               step_in  = 4'd5;
               state_in = ST_MINS;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_MINS: begin
            if (sub_ge) rem_in = sub_diff;
            min_in = {min_ff[4:0], sub_ge};
            if (step_ff == 4'd0) begin
               // What is left is the second; reload with the day count.
               sec_in   = sub_ge ? sub_diff[5:0] : rem_ff[5:0];
               rem_in   = {16'd0, days_ff};
               year_in  = BaseYear;
               state_in = ST_YEARS;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_YEARS: begin
            if (sub_ge) begin
               rem_in  = sub_diff;
               year_in = year_ff + 12'd1;
            end else begin
               mon_in   = 4'd0;
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            // December always takes whatever days remain.
            if (sub_ge && (mon_ff != LastMonth)) begin
               rem_in = sub_diff;
               mon_in = mon_ff + 4'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      days_ff <= days_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      sec_ff  <= sec_in;
      year_ff <= year_in;
      mon_ff  <= mon_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   assign result.day_of_month     = rem_ff[4:0] + 5'd1;
   assign result.month_number     = mon_ff + 4'd1;
   assign result.year_number      = year_ff;
   assign result.hour_of_day      = hour_ff;
   assign result.minute_of_hour   = min_ff;
   assign result.second_of_minute = sec_ff;

endmodule

// ===== design/epoch_seconds_to_calendar.sv =====
// Channel   Direction  Ports         Word contents
// req       in         req_t*        epoch_seconds
// rsp       out        rsp_t*        day, month, year, hour, minute, second
//
// Each word runs long division through the single subtractor: days, then
// hours, then minutes. Then the sequencer steps once per elapsed year and once
// per month stepped, closes each walk and hands off the result from its done
// state; the year walk sets most of the time that a word takes.
// Reset is synchronous and returns the sequencer to idle with no result pending.
// A new word is taken while a finished result waits in the output register;
// a stalled output holds the sequencer in its done state once a second result is ready.
module epoch_seconds_to_calendar import esc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] epoch_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] day_of_month, [8:5] month_number, [20:9] year_number,
   // [25:21] hour_of_day, [31:26] minute_of_hour, [37:32] second_of_minute, [39:38] zero
   output logic [39:0] rsp_tdata
);

   esc_status_type status;
   esc_result_type result;
   logic           start, take;
   logic           rsp_valid_ff, rsp_valid_in;
   esc_result_type rsp_data_ff, rsp_data_in;

   assign req_tready = status.idle;
   assign start      = req_tvalid & req_tready;
   assign take       = status.done & (~rsp_valid_ff | rsp_tready);

   esc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .secs   (req_tdata),
      .take   (take),
      .status (status),
      .result (result)
   );

   assign rsp_valid_in = take | (rsp_valid_ff & ~rsp_tready);
   assign rsp_data_in  = take ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer took a word but stayed idle");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:5] >= 4'd1 && rsp_tdata[8:5] <= 4'd12))
      else $error("month out of range");

   a_day_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] != 5'd0 && rsp_tdata[25:21] <= 5'd23
                      && rsp_tdata[31:26] <= 6'd59 && rsp_tdata[37:32] <= 6'd59))
      else $error("day or time of day out of range");

endmodule
